[rtl/crse_pkg.sv]
// ----------------------------------------------------------------------------
// crse_pkg
// shared constants, widths and types of the character raster shape engine
// ----------------------------------------------------------------------------
package crse_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;

  localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int COL_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int WCNT_W      = $clog2(MAX_COLS + 1);
  localparam int HCNT_W      = $clog2(MAX_ROWS + 1);

  localparam int CRD_W = 10;
  localparam int SQ_W  = 18;
  localparam int D2_W  = 20;

  localparam int CHAR_W = 8;
  localparam int SIZE_W = 7;
  localparam int DATA_W = 32;
  localparam int PADDR_W = 3;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    REQ_CLEAR     = 3'd0,
    REQ_POINT     = 3'd1,
    REQ_CIRCLE    = 3'd2,
    REQ_DISC      = 3'd3,
    REQ_RECT      = 3'd4,
    REQ_RECT_FILL = 3'd5,
    REQ_READ      = 3'd6
  } req_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_SETUP = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_POINT = 7'b0010000,
    S_READ  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

endpackage

[rtl/crse_ram.sv]
// ----------------------------------------------------------------------------
// crse_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module crse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/char_raster_shape_engine.sv]
// ----------------------------------------------------------------------------
// char_raster_shape_engine
// character framebuffer with clear, point, circle, disc, rectangle and read
// ----------------------------------------------------------------------------
// One command word enters on the in_ channel (in_valid / in_stall). Shape
// commands first run setup steps, in which one shared multiplier forms the
// center and radius squares, then scan the canvas cell by cell, row by row,
// keeping the squared distances up to date by additions. Clear writes every
// store cell (MAX_COLS * MAX_ROWS); a point writes at most one cell. A read
// goes through the registered store port (S_READ, S_RESP) and then sits in
// the output register until taken on the out_ channel; while out_stall holds
// it there a further read waits, and in_stall stays high until the word is
// loaded. in_stall is high whenever a command is in progress. After reset
// the block clears all MAX_COLS * MAX_ROWS (4096) store cells to spaces,
// with in_stall high. Canvas size is written over the APB port at address
// 0 (width) and 4 (height); the user must do so only while the block is
// idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module char_raster_shape_engine
  import crse_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               in_req_type,
  input  logic signed [7:0]        in_x_first,
  input  logic signed [7:0]        in_y_first,
  input  logic signed [7:0]        in_x_second,
  input  logic signed [7:0]        in_y_second,
  input  logic [6:0]               in_radius,
  input  logic [CHAR_W-1:0]        in_glyph,

  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CHAR_W-1:0]        out_cell_value,

  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0] canvas_width_r, canvas_width_nxt;
  logic [SIZE_W-1:0] canvas_height_r, canvas_height_nxt;

  req_t                op_r, op_nxt;
  logic signed [7:0]   x1_r, x1_nxt, y1_r, y1_nxt, x2_r, x2_nxt, y2_r, y2_nxt;
  logic [6:0]          rad_r, rad_nxt;
  logic [CHAR_W-1:0]   glyph_r, glyph_nxt;

  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [1:0]          step_r, step_nxt;
  logic [COL_W-1:0]    x_r, x_nxt;
  logic [ROW_W-1:0]    y_r, y_nxt;
  logic [ADDR_W-1:0]   row_base_r, row_base_nxt;
  logic signed [CRD_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [SQ_W-1:0]     dxsq_r, dxsq_nxt, dysq_r, dysq_nxt, x1sq_r, x1sq_nxt;
  logic [SQ_W-1:0]     rsq_r, rsq_nxt, r1sq_r, r1sq_nxt;
  logic                rd_in_r, rd_in_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_value_r, out_value_nxt;

  logic [WCNT_W-1:0]   w_eff;
  logic [HCNT_W-1:0]   h_eff;
  logic [COL_W-1:0]    x_last;
  logic [ROW_W-1:0]    y_last;
  logic                in_canvas;
  logic [ADDR_W-1:0]   pt_addr;

  logic signed [CRD_W-1:0] xs, ys, x1s, y1s, x2s, y2s;
  logic [D2_W-1:0]     d2;
  logic                covered;
  logic signed [CRD_W-1:0] mul_a;
  logic signed [2*CRD_W-1:0] mul_p;
  logic signed [D2_W-1:0] dxsq_inc, dysq_inc;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [CHAR_W-1:0]   ram_wdata, ram_rdata;
  logic                accept, cfg_wr;

  crse_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (pt_addr),
    .rdata (ram_rdata)
  );

  // effective canvas size
  always_comb begin
    if (canvas_width_r == '0) begin
      w_eff = WCNT_W'(1);
    end else if (int'(canvas_width_r) > MAX_COLS) begin
      w_eff = WCNT_W'(MAX_COLS);
    end else begin
      w_eff = WCNT_W'(canvas_width_r);
    end
    if (canvas_height_r == '0) begin
      h_eff = HCNT_W'(1);
    end else if (int'(canvas_height_r) > MAX_ROWS) begin
      h_eff = HCNT_W'(MAX_ROWS);
    end else begin
      h_eff = HCNT_W'(canvas_height_r);
    end
  end

  assign x_last = COL_W'(w_eff - WCNT_W'(1));
  assign y_last = ROW_W'(h_eff - HCNT_W'(1));

  assign x1s = CRD_W'(x1_r);
  assign y1s = CRD_W'(y1_r);
  assign x2s = CRD_W'(x2_r);
  assign y2s = CRD_W'(y2_r);
  assign xs  = $signed(CRD_W'(x_r));
  assign ys  = $signed(CRD_W'(y_r));

  assign in_canvas = (x1s >= 0) && (x1s < $signed(CRD_W'(w_eff))) &&
                     (y1s >= 0) && (y1s < $signed(CRD_W'(h_eff)));
  assign pt_addr = ADDR_W'(int'($unsigned(y1_r)) * MAX_COLS + int'($unsigned(x1_r)));

  // coverage test of the current cell
  assign d2 = D2_W'(dxsq_r) + D2_W'(dysq_r);

  always_comb begin
    unique case (op_r)
      REQ_CIRCLE:    covered = (d2 + D2_W'(1) >= D2_W'(rsq_r)) &&
                               (d2 <= D2_W'(rsq_r) + D2_W'(1));
      REQ_DISC:      covered = d2 < D2_W'(r1sq_r);
      REQ_RECT:      covered = ((ys == y1s || ys == y2s) && xs >= x1s && xs <= x2s) ||
                               ((xs == x1s || xs == x2s) && ys >= y1s && ys <= y2s);
      REQ_RECT_FILL: covered = xs > x1s && xs < x2s && ys > y1s && ys < y2s;
      default:       covered = 1'b0;
    endcase
  end

  // shared squaring unit for setup
  always_comb begin
    unique case (step_r)
      2'd0:    mul_a = x1s;
      2'd1:    mul_a = y1s;
      2'd2:    mul_a = $signed(CRD_W'(rad_r));
      default: mul_a = $signed(CRD_W'(rad_r)) + CRD_W'(1);
    endcase
  end

  assign mul_p = mul_a * mul_a;

  assign dxsq_inc = $signed(D2_W'(dxsq_r)) + (D2_W'(dx_r) <<< 1) + D2_W'(1);
  assign dysq_inc = $signed(D2_W'(dysq_r)) + (D2_W'(dy_r) <<< 1) + D2_W'(1);

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;

  // sequencer
  always_comb begin
    state_nxt         = state_r;
    canvas_width_nxt  = canvas_width_r;
    canvas_height_nxt = canvas_height_r;
    op_nxt            = op_r;
    x1_nxt            = x1_r;
    y1_nxt            = y1_r;
    x2_nxt            = x2_r;
    y2_nxt            = y2_r;
    rad_nxt           = rad_r;
    glyph_nxt         = glyph_r;
    clr_cnt_nxt       = clr_cnt_r;
    step_nxt          = step_r;
    x_nxt             = x_r;
    y_nxt             = y_r;
    row_base_nxt      = row_base_r;
    dx_nxt            = dx_r;
    dy_nxt            = dy_r;
    dxsq_nxt          = dxsq_r;
    dysq_nxt          = dysq_r;
    x1sq_nxt          = x1sq_r;
    rsq_nxt           = rsq_r;
    r1sq_nxt          = r1sq_r;
    rd_in_nxt         = rd_in_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_value_nxt     = out_value_r;
    ram_we            = 1'b0;
    ram_re            = 1'b0;
    ram_waddr         = clr_cnt_r;
    ram_wdata         = SPACE_CHAR;

    if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDTH:  canvas_width_nxt  = pwdata[SIZE_W-1:0];
        REG_HEIGHT: canvas_height_nxt = pwdata[SIZE_W-1:0];
        default:    ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = req_t'(in_req_type);
          x1_nxt    = in_x_first;
          y1_nxt    = in_y_first;
          x2_nxt    = in_x_second;
          y2_nxt    = in_y_second;
          rad_nxt   = in_radius;
          glyph_nxt = in_glyph;
          step_nxt  = 2'd0;
          clr_cnt_nxt = '0;
          unique case (req_t'(in_req_type))
            REQ_CLEAR:     state_nxt = S_CLEAR;
            REQ_POINT:     state_nxt = S_POINT;
            REQ_CIRCLE,
            REQ_DISC,
            REQ_RECT,
            REQ_RECT_FILL: state_nxt = S_SETUP;
            REQ_READ:      state_nxt = S_READ;
            default:       state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = SPACE_CHAR;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(STORE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_SETUP: begin
        step_nxt = step_r + 2'd1;
        unique case (step_r)
          2'd0: begin
            x1sq_nxt     = SQ_W'(mul_p);
            dxsq_nxt     = SQ_W'(mul_p);
            dx_nxt       = -x1s;
            dy_nxt       = -y1s;
            x_nxt        = '0;
            y_nxt        = '0;
            row_base_nxt = '0;
          end
          2'd1: dysq_nxt = SQ_W'(mul_p);
          2'd2: rsq_nxt  = SQ_W'(mul_p);
          default: begin
            r1sq_nxt  = SQ_W'(mul_p);
            state_nxt = S_SCAN;
          end
        endcase
      end
      S_SCAN: begin
        ram_we    = covered;
        ram_waddr = row_base_r + ADDR_W'(x_r);
        ram_wdata = glyph_r;
        if (x_r == x_last) begin
          x_nxt    = '0;
          dx_nxt   = -x1s;
          dxsq_nxt = x1sq_r;
          if (y_r == y_last) begin
            state_nxt = S_IDLE;
          end else begin
            y_nxt        = y_r + ROW_W'(1);
            dy_nxt       = dy_r + CRD_W'(1);
            dysq_nxt     = SQ_W'(dysq_inc);
            row_base_nxt = row_base_r + ADDR_W'(MAX_COLS);
          end
        end else begin
          x_nxt    = x_r + COL_W'(1);
          dx_nxt   = dx_r + CRD_W'(1);
          dxsq_nxt = SQ_W'(dxsq_inc);
        end
      end
      S_POINT: begin
        ram_we    = in_canvas;
        ram_waddr = pt_addr;
        ram_wdata = glyph_r;
        state_nxt = S_IDLE;
      end
      S_READ: begin
        ram_re    = in_canvas;
        rd_in_nxt = in_canvas;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = rd_in_r ? ram_rdata : SPACE_CHAR;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      clr_cnt_r       <= '0;
      step_r          <= '0;
      canvas_width_r  <= SIZE_W'(MAX_COLS);
      canvas_height_r <= SIZE_W'(MAX_ROWS);
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      clr_cnt_r       <= clr_cnt_nxt;
      step_r          <= step_nxt;
      canvas_width_r  <= canvas_width_nxt;
      canvas_height_r <= canvas_height_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    x1_r       <= x1_nxt;
    y1_r       <= y1_nxt;
    x2_r       <= x2_nxt;
    y2_r       <= y2_nxt;
    rad_r      <= rad_nxt;
    glyph_r    <= glyph_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    row_base_r <= row_base_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    dxsq_r     <= dxsq_nxt;
    dysq_r     <= dysq_nxt;
    x1sq_r     <= x1sq_nxt;
    rsq_r      <= rsq_nxt;
    r1sq_r     <= r1sq_nxt;
    rd_in_r    <= rd_in_nxt;
    out_value_r <= out_value_nxt;
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_WIDTH:  prdata = DATA_W'(canvas_width_r);
      REG_HEIGHT: prdata = DATA_W'(canvas_height_r);
      default:    prdata = '0;
    endcase
  end

  assign pready         = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_cell_value = out_value_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_req_type == REQ_READ) |=> state_r == S_READ ##1 state_r == S_RESP)
    else $error("read command did not go through the store read");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_SETUP) |-> !ram_we)
    else $error("store written outside a drawing step");

  a_scan_in_canvas: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> (WCNT_W'(x_r) < w_eff) && (HCNT_W'(y_r) < h_eff))
    else $error("scan left the canvas");

  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_RESP)
    else $error("result word raised outside the response step");

endmodule

[dv/tb_char_raster_shape_engine.sv]
// ----------------------------------------------------------------------------
// tb_char_raster_shape_engine
// self-checking bench for the character raster shape engine: drives drawing
// words and canvas sizes, tracks its own copy of the frame and checks every
// cell word read back against it, under random idling on both channels
// ----------------------------------------------------------------------------
module tb_char_raster_shape_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import crse_pkg::*;

  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam int SETTLE = STORE_DEPTH + 16;
  localparam int LIMIT  = 3_000_000;

  typedef struct {
    logic [2:0]        op;
    logic signed [7:0] x1;
    logic signed [7:0] y1;
    logic signed [7:0] x2;
    logic signed [7:0] y2;
    logic [6:0]        r;
    logic [7:0]        g;
  } draw_word_t;

  class raster_scoreboard;
    logic [CHAR_W-1:0] cells [STORE_DEPTH];
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [CHAR_W-1:0] expected_cells [$];
    int                errors;

    function new();
      foreach (cells[i]) cells[i] = SPACE_CHAR;
      width_reg  = 7'd64;
      height_reg = 7'd64;
      errors     = 0;
    endfunction

    function int clamp_size(logic [SIZE_W-1:0] v, int maxv);
      int s;
      s = int'(v);
      if (s < 1) s = 1;
      if (s > maxv) s = maxv;
      return s;
    endfunction

    function int cols();
      return clamp_size(width_reg, MAX_COLS);
    endfunction

    function int rows();
      return clamp_size(height_reg, MAX_ROWS);
    endfunction

    function void set_canvas(logic idx, logic [SIZE_W-1:0] v);
      if (idx == REG_WIDTH) width_reg = v;
      else height_reg = v;
    endfunction

    function bit covers(int x, int y, draw_word_t c);
      int x1, y1, x2, y2, r, d2, e;
      x1 = c.x1;
      y1 = c.y1;
      x2 = c.x2;
      y2 = c.y2;
      r  = int'(c.r);
      d2 = (x - x1) * (x - x1) + (y - y1) * (y - y1);
      case (c.op)
        REQ_CIRCLE: begin
          e = d2 - r * r;
          return (e > -2) && (e < 2);
        end
        REQ_DISC:   return d2 < (r + 1) * (r + 1);
        REQ_RECT:   return ((y == y1 || y == y2) && x >= x1 && x <= x2) ||
                           ((x == x1 || x == x2) && y >= y1 && y <= y2);
        REQ_RECT_FILL: return x > x1 && x < x2 && y > y1 && y < y2;
        default:    return 1'b0;
      endcase
    endfunction

    function void note_command(draw_word_t c);
      int w, h, x1, y1;
      bit on_canvas;
      w  = cols();
      h  = rows();
      x1 = c.x1;
      y1 = c.y1;
      on_canvas = x1 >= 0 && x1 < w && y1 >= 0 && y1 < h;
      case (c.op)
        REQ_CLEAR: foreach (cells[i]) cells[i] = SPACE_CHAR;
        REQ_POINT: if (on_canvas) cells[y1 * MAX_COLS + x1] = c.g;
        REQ_CIRCLE, REQ_DISC, REQ_RECT, REQ_RECT_FILL: begin
          for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
              if (covers(x, y, c)) cells[y * MAX_COLS + x] = c.g;
        end
        REQ_READ: begin
          expected_cells.push_back(on_canvas ? cells[y1 * MAX_COLS + x1] : SPACE_CHAR);
        end
        default: ;
      endcase
    endfunction

    function void check_cell(logic [CHAR_W-1:0] got);
      logic [CHAR_W-1:0] want;
      if (expected_cells.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected cell word: got %0d", got);
        return;
      end
      want = expected_cells.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("cell_value mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [2:0]          in_req_type;
  logic signed [7:0]   in_x_first;
  logic signed [7:0]   in_y_first;
  logic signed [7:0]   in_x_second;
  logic signed [7:0]   in_y_second;
  logic [6:0]          in_radius;
  logic [CHAR_W-1:0]   in_glyph;
  logic                out_valid;
  logic                out_stall;
  logic [CHAR_W-1:0]   out_cell_value;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  raster_scoreboard    sb = new();
  bit                  quiet = 1'b0;
  int                  cycle_count = 0;

  char_raster_shape_engine uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_x_first     (in_x_first),
    .in_y_first     (in_y_first),
    .in_x_second    (in_x_second),
    .in_y_second    (in_y_second),
    .in_radius      (in_radius),
    .in_glyph       (in_glyph),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cell_value (out_cell_value),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("tb_char_raster_shape_engine: done, errors");
      $finish;
    end
  end

  function automatic int draw_gap();
    return quiet ? 0 : int'($urandom_range(0, 13));
  endfunction

  function automatic draw_word_t word(logic [2:0] op, int x1, int y1, int x2, int y2,
                                      int r, int g);
    draw_word_t c;
    c.op = op;
    c.x1 = 8'(x1);
    c.y1 = 8'(y1);
    c.x2 = 8'(x2);
    c.y2 = 8'(y2);
    c.r  = 7'(r);
    c.g  = 8'(g);
    return c;
  endfunction

  function automatic logic signed [7:0] coord(int span);
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return 8'(int'($urandom_range(0, span + 7)) - 4);
  endfunction

  function automatic draw_word_t random_word(int w, int h);
    draw_word_t        c;
    int                pick;
    logic signed [7:0] t;
    pick = $urandom_range(0, 99);
    c.op = pick < 3  ? REQ_UNUSED :
           pick < 6  ? REQ_CLEAR :
           pick < 20 ? REQ_POINT :
           pick < 30 ? REQ_CIRCLE :
           pick < 40 ? REQ_DISC :
           pick < 50 ? REQ_RECT :
           pick < 58 ? REQ_RECT_FILL : REQ_READ;
    c.x1 = coord(w);
    c.y1 = coord(h);
    c.x2 = coord(w);
    c.y2 = coord(h);
    // mostly well-ordered corners, some reversed
    if ((c.op == REQ_RECT || c.op == REQ_RECT_FILL) && $urandom_range(0, 3) != 0) begin
      if (c.x1 > c.x2) begin
        t = c.x1; c.x1 = c.x2; c.x2 = t;
      end
      if (c.y1 > c.y2) begin
        t = c.y1; c.y1 = c.y2; c.y2 = t;
      end
    end
    c.r = ($urandom_range(0, 7) == 0) ? 7'($urandom)
                                      : 7'($urandom_range(0, (w > h ? w : h) / 2 + 2));
    c.g = 8'($urandom);
    return c;
  endfunction

  task automatic send_word(draw_word_t c);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req_type <= c.op;
    in_x_first  <= c.x1;
    in_y_first  <= c.y1;
    in_x_second <= c.x2;
    in_y_second <= c.y2;
    in_radius   <= c.r;
    in_glyph    <= c.g;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_command(c);
  endtask

  task automatic cfg_write(logic idx, logic [SIZE_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {25'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    sb.set_canvas(idx, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      hold = draw_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      sb.check_cell(out_cell_value);
    end
  end

  initial begin
    int               counted;
    logic [SIZE_W-1:0] wv, hv;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_req_type <= REQ_CLEAR;
    in_x_first  <= '0;
    in_y_first  <= '0;
    in_x_second <= '0;
    in_y_second <= '0;
    in_radius   <= '0;
    in_glyph    <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed words on the full canvas
    send_word(word(REQ_READ, 0, 0, 0, 0, 0, 0));
    send_word(word(REQ_POINT, 0, 0, 0, 0, 0, 8'hFF));
    send_word(word(REQ_POINT, 63, 63, -128, 127, 127, 8'h00));
    send_word(word(REQ_POINT, -1, 5, 0, 0, 0, 8'h41));
    send_word(word(REQ_POINT, 64, 0, 0, 0, 0, 8'h42));
    send_word(word(REQ_POINT, -128, 127, 0, 0, 0, 8'h43));
    send_word(word(REQ_READ, 0, 0, 0, 0, 0, 0));
    send_word(word(REQ_READ, 63, 63, 0, 0, 0, 0));
    send_word(word(REQ_READ, -128, -128, 127, 127, 127, 8'hFF));
    send_word(word(REQ_READ, 127, 127, 0, 0, 0, 0));
    send_word(word(REQ_CIRCLE, 20, 20, 0, 0, 10, 8'h6F));
    send_word(word(REQ_READ, 30, 20, 0, 0, 0, 0));
    send_word(word(REQ_CIRCLE, 2, 2, 0, 0, 0, 8'h2B));
    send_word(word(REQ_DISC, -128, -128, 0, 0, 127, 8'h2A));
    send_word(word(REQ_DISC, 10, 50, 0, 0, 0, 8'h40));
    send_word(word(REQ_RECT, 5, 5, 40, 30, 0, 8'h23));
    send_word(word(REQ_READ, 40, 30, 0, 0, 0, 0));
    send_word(word(REQ_RECT_FILL, 5, 5, 40, 30, 0, 8'h2E));
    send_word(word(REQ_READ, 6, 6, 0, 0, 0, 0));
    send_word(word(REQ_RECT, 40, 30, 5, 5, 0, 8'h58));
    send_word(word(REQ_RECT, -128, -128, 127, 127, 0, 8'h7C));
    send_word(word(REQ_CIRCLE, 0, 0, 0, 0, 127, 8'h80));
    send_word(word(REQ_UNUSED, 1, 1, 1, 1, 1, 8'h55));
    send_word(word(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
    send_word(word(REQ_READ, 0, 0, 0, 0, 0, 0));

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin wv = 7'd0;   hv = 7'd0;  end
        1: begin wv = 7'd127; hv = 7'd1;  end
        2: begin wv = 7'd1;   hv = 7'd65; end
        3: begin
          wv = 7'($urandom_range(2, 12));
          hv = 7'($urandom_range(2, 12));
        end
        4: begin
          wv = 7'($urandom_range(2, 20));
          hv = 7'($urandom_range(2, 20));
        end
        5: begin
          wv = 7'($urandom_range(1, 127));
          hv = 7'($urandom_range(1, 8));
        end
        default: begin wv = 7'd64; hv = 7'd64; end
      endcase
      wait_idle();
      cfg_write(REG_WIDTH, wv);
      cfg_write(REG_HEIGHT, hv);
      quiet = (p == 1 || p == 4);
      counted = 0;
      while (counted < 16) begin
        draw_word_t c;
        c = random_word(sb.cols(), sb.rows());
        if (c.op != REQ_UNUSED) counted++;
        send_word(c);
      end
    end

    wait_idle();
    if (sb.errors == 0 && sb.expected_cells.size() == 0) begin
      $display("tb_char_raster_shape_engine: done, clean");
    end else begin
      $display("tb_char_raster_shape_engine: done, errors");
    end
    $finish;
  end

endmodule
